[hdl/fvslm_pkg.sv]
package fvslm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SET     = 2'd1,
    OP_SILENCE = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_SAMPLE_LENGTH = 1'b0,
    REG_ENGINE_MUTED  = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_TICK_RD,
    ST_GLIDE,
    ST_MOD,
    ST_RD_A,
    ST_RD_B,
    ST_INTERP,
    ST_VOLUME,
    ST_PAN,
    ST_MIX,
    ST_DONE
  } state_e;

  localparam int unsigned CfgW      = 13;
  localparam int unsigned StepW     = 18;
  localparam logic [13:0] PitchBase = 14'h0700;
  localparam logic [13:0] PitchMul  = 14'd34;
  localparam logic [15:0] StepMul   = 16'd47554;
  localparam logic [7:0]  GlideMul  = 8'd131;
  localparam logic [14:0] PanMul    = 15'd26214;
  localparam logic [15:0] GainFloor = 16'd33;
  localparam logic signed [15:0] OutMax = 16'sd32767;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
  } mem_ctl_t;

endpackage

[hdl/fvslm_sample_mem.sv]
module fvslm_sample_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                  clk_i,
  input  fvslm_pkg::mem_ctl_t   ctl_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic signed [15:0]    wr_data_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic signed [15:0]    rd_data_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = $signed(rd_data_q);

endmodule

[hdl/fvslm_voice_mem.sv]
module fvslm_voice_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2,
  parameter int unsigned WIDTH = 110
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fvslm_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [WIDTH-1:0]    rd_data_o,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [WIDTH-1:0]    wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

[hdl/four_voice_sample_loop_mixer_top.sv]
// Channel      Direction  Handshake                 Payload
// s_axis       in         s_axis_tvalid/tready      tuser op, tdata voice and sample fields
// m_axis       out        m_axis_tvalid/tready      tdata left and right sample
// cfg          in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A load is written from the idle state. A voice set reads the voice entry and writes it
// back; a silence-all request does so for each voice in turn. A tick reads, glides,
// interpolates, scales, pans and mixes each voice, skips one faded below the gain floor, and
// first reduces a phase beyond a shortened loop in log2(SAMPLE_DEPTH) remainder steps.
// The voice memory is reset to read as zero, so it needs no clearing. A tick whose result
// finds the output register still full waits there until the output transaction completes.
module four_voice_sample_loop_mixer_top #(
  parameter int unsigned VOICE_COUNT  = 4,
  parameter int unsigned SAMPLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // voice_index[1:0], rev_value[8:2], target_volume[24:9], target_pan[40:25],
  // sample_address[52:41], sample_word[68:53], zero fill [71:69]
  input  logic [71:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_sample[15:0], right_sample[31:16]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int unsigned IdxW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned LenW = IdxW + 1;
  localparam int unsigned PhW  = IdxW + 16;
  localparam int unsigned SpW  = PhW + 1;
  localparam int unsigned MW   = SpW + IdxW;
  localparam int unsigned KW   = $clog2(IdxW + 1);
  localparam int unsigned NW   = ((PhW > fvslm_pkg::StepW) ? PhW : fvslm_pkg::StepW) + 2;
  localparam int unsigned ViW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned AccW = 18 + $clog2(VOICE_COUNT + 1);
  localparam int unsigned VW   = PhW + fvslm_pkg::StepW + 64;

  fvslm_pkg::state_e st_q, st_d;

  logic [12:0]     len_cfg_q;
  logic            muted_q;
  logic [ViW-1:0]  vidx_q, vidx_d;
  logic [6:0]      rev_q;
  logic [15:0]     vol_q;
  logic [15:0]     pan_q;
  logic [MW-1:0]   rem_q, rem_d;
  logic [KW-1:0]   kcnt_q, kcnt_d;
  logic [fvslm_pkg::StepW-1:0] step_q, step_d;
  logic [15:0]     gain_q, gain_d, gtgt_q, gtgt_d;
  logic signed [15:0] bal_q, bal_d, btgt_q, btgt_d;
  logic signed [15:0] a_q, a_d;
  logic signed [16:0] s_q, s_d, g_q, g_d;
  logic [NW-1:0]   nph_q, nph_d;
  logic signed [AccW-1:0] accl_q, accl_d, accr_q, accr_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_data_q, out_data_d;

  fvslm_pkg::mem_ctl_t vctl, sctl;
  logic [VW-1:0]   vrd, vwr;
  logic [ViW-1:0]  vaddr;
  logic [IdxW-1:0] s_rd_addr;
  logic signed [15:0] s_rd;

  logic [LenW-1:0] len_eff;
  logic [SpW-1:0]  span;
  logic            accept;
  logic [1:0]      in_op;
  logic [IdxW-1:0] ld_addr;
  logic            ld_ok;

  logic [PhW-1:0]  v_ph;
  logic [fvslm_pkg::StepW-1:0] v_step;
  logic [15:0]     v_g, v_gt;
  logic signed [15:0] v_b, v_bt;
  logic signed [16:0] gdiff, bdiff;
  logic signed [25:0] gprod, bprod;
  logic signed [16:0] gnew17;
  logic [15:0]     gnew;
  logic signed [15:0] bnew;
  logic [13:0]     pitch;
  logic [29:0]     step_prod;
  logic [fvslm_pkg::StepW-1:0] step_new;
  logic            silence;
  logic [MW-1:0]   mod_span;
  logic [IdxW-1:0] jidx, bidx;
  logic [IdxW:0]   jnext;
  logic [15:0]     frac;
  logic signed [33:0] iprod;
  logic signed [33:0] vprod;
  logic [15:0]     pabs;
  logic [30:0]     pprod;
  logic signed [33:0] cprod;
  logic signed [16:0] contrib;
  logic [NW-1:0]   nsum, span_n;
  logic            last_voice;
  logic signed [AccW-1:0] lim_hi, lim_lo;
  logic [15:0]     left_c, right_c;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_op     = s_axis_tuser;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (st_q == fvslm_pkg::ST_IDLE);

  assign len_eff = ({19'd0, len_cfg_q} > 32'(SAMPLE_DEPTH)) ? LenW'(SAMPLE_DEPTH)
                                                             : LenW'(len_cfg_q);
  assign span    = {len_eff, 16'd0};
  assign ld_addr = IdxW'(s_axis_tdata[52:41]);
  assign ld_ok   = 32'(s_axis_tdata[52:41]) < 32'(SAMPLE_DEPTH);

  assign v_bt   = $signed(vrd[15:0]);
  assign v_b    = $signed(vrd[31:16]);
  assign v_gt   = vrd[47:32];
  assign v_g    = vrd[63:48];
  assign v_step = vrd[64 +: fvslm_pkg::StepW];
  assign v_ph   = vrd[VW-1 -: PhW];

  assign gdiff  = $signed({1'b0, v_gt}) - $signed({1'b0, v_g});
  assign gprod  = 26'(gdiff) * $signed({18'd0, fvslm_pkg::GlideMul});
  assign gnew17 = $signed({1'b0, v_g}) + 17'(gprod >>> 16);
  assign gnew   = gnew17[15:0];
  assign bdiff  = 17'(v_bt) - 17'(v_b);
  assign bprod  = 26'(bdiff) * $signed({18'd0, fvslm_pkg::GlideMul});
  assign bnew   = v_b + 16'(bprod >>> 16);

  assign pitch     = fvslm_pkg::PitchBase + fvslm_pkg::PitchMul * {7'd0, rev_q};
  assign step_prod = 30'(pitch) * 30'(fvslm_pkg::StepMul);
  assign step_new  = step_prod[12 +: fvslm_pkg::StepW];
  assign silence   = (rev_q == 7'd0) || (vol_q == 16'd0) || muted_q;

  assign mod_span = MW'(span) << kcnt_q;
  assign jidx     = rem_q[16 +: IdxW];
  assign frac     = rem_q[15:0];
  assign jnext    = {1'b0, jidx} + {{IdxW{1'b0}}, 1'b1};
  assign bidx     = (jnext == len_eff) ? '0 : jnext[IdxW-1:0];

  assign iprod   = 34'(s_rd - a_q) * $signed({18'd0, frac});
  assign vprod   = 34'(s_q) * $signed({18'd0, gain_q});
  assign pabs    = (bal_q < 0) ? 16'(-17'(bal_q)) : bal_q;
  assign pprod   = 31'(pabs) * 31'(fvslm_pkg::PanMul);
  assign cprod   = 34'(s_q) * 34'(g_q);
  assign contrib = 17'(cprod >>> 15);
  assign nsum    = NW'(rem_q[PhW-1:0]) + NW'(step_q);
  assign span_n  = NW'(span);

  assign last_voice = (vidx_q == ViW'(VOICE_COUNT - 1));
  assign lim_hi = AccW'(fvslm_pkg::OutMax);
  assign lim_lo = -AccW'(fvslm_pkg::OutMax);
  assign left_c  = (accl_q > lim_hi) ? fvslm_pkg::OutMax :
                   (accl_q < lim_lo) ? -fvslm_pkg::OutMax : 16'(accl_q);
  assign right_c = (accr_q > lim_hi) ? fvslm_pkg::OutMax :
                   (accr_q < lim_lo) ? -fvslm_pkg::OutMax : 16'(accr_q);

  always_comb begin
    st_d        = st_q;
    vidx_d      = vidx_q;
    rem_d       = rem_q;
    kcnt_d      = kcnt_q;
    step_d      = step_q;
    gain_d      = gain_q;
    gtgt_d      = gtgt_q;
    bal_d       = bal_q;
    btgt_d      = btgt_q;
    a_d         = a_q;
    s_d         = s_q;
    g_d         = g_q;
    nph_d       = nph_q;
    accl_d      = accl_q;
    accr_d      = accr_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    vctl        = '0;
    sctl        = '0;
    vaddr       = vidx_q;
    vwr         = vrd;
    s_rd_addr   = jidx;
    unique case (st_q)
      fvslm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (fvslm_pkg::op_e'(in_op))
            fvslm_pkg::OP_LOAD: begin
              sctl.wr_en = ld_ok;
            end
            fvslm_pkg::OP_SET: begin
              vidx_d = ViW'(s_axis_tdata[1:0]);
              if (32'(s_axis_tdata[1:0]) < 32'(VOICE_COUNT)) begin
                st_d = fvslm_pkg::ST_SET_RD;
              end
            end
            fvslm_pkg::OP_SILENCE: begin
              vidx_d = '0;
              st_d   = fvslm_pkg::ST_CLR_RD;
            end
            fvslm_pkg::OP_TICK: begin
              vidx_d = '0;
              accl_d = '0;
              accr_d = '0;
              st_d   = (len_eff < LenW'(2)) ? fvslm_pkg::ST_DONE : fvslm_pkg::ST_TICK_RD;
            end
            default: ;
          endcase
        end
      end
      fvslm_pkg::ST_SET_RD: begin
        vctl.rd_en = 1'b1;
        st_d       = fvslm_pkg::ST_SET_WR;
      end
      fvslm_pkg::ST_SET_WR: begin
        vctl.wr_en = 1'b1;
        if (silence) begin
          vwr = {v_ph, v_step, v_g, 16'd0, v_b, v_bt};
        end else begin
          vwr = {v_ph, step_new, v_g, vol_q, v_b, pan_q};
        end
        st_d = fvslm_pkg::ST_IDLE;
      end
      fvslm_pkg::ST_CLR_RD: begin
        vctl.rd_en = 1'b1;
        st_d       = fvslm_pkg::ST_CLR_WR;
      end
      fvslm_pkg::ST_CLR_WR: begin
        vctl.wr_en = 1'b1;
        vwr        = {v_ph, v_step, v_g, 16'd0, v_b, v_bt};
        vidx_d     = vidx_q + ViW'(1);
        st_d       = last_voice ? fvslm_pkg::ST_IDLE : fvslm_pkg::ST_CLR_RD;
      end
      fvslm_pkg::ST_TICK_RD: begin
        vctl.rd_en = 1'b1;
        st_d       = fvslm_pkg::ST_GLIDE;
      end
      fvslm_pkg::ST_GLIDE: begin
        step_d = v_step;
        gain_d = gnew;
        gtgt_d = v_gt;
        bal_d  = bnew;
        btgt_d = v_bt;
        rem_d  = MW'(v_ph);
        kcnt_d = KW'(IdxW - 1);
        if (gnew < fvslm_pkg::GainFloor) begin
          vctl.wr_en = 1'b1;
          vwr        = {v_ph, v_step, gnew, v_gt, bnew, v_bt};
          vidx_d     = vidx_q + ViW'(1);
          st_d       = last_voice ? fvslm_pkg::ST_DONE : fvslm_pkg::ST_TICK_RD;
        end else if (SpW'(v_ph) >= span) begin
          st_d = fvslm_pkg::ST_MOD;
        end else begin
          st_d = fvslm_pkg::ST_RD_A;
        end
      end
      fvslm_pkg::ST_MOD: begin
        if (rem_q >= mod_span) begin
          rem_d = rem_q - mod_span;
        end
        kcnt_d = kcnt_q - KW'(1);
        if (kcnt_q == '0) begin
          st_d = fvslm_pkg::ST_RD_A;
        end
      end
      fvslm_pkg::ST_RD_A: begin
        sctl.rd_en = 1'b1;
        s_rd_addr  = jidx;
        st_d       = fvslm_pkg::ST_RD_B;
      end
      fvslm_pkg::ST_RD_B: begin
        a_d        = s_rd;
        sctl.rd_en = 1'b1;
        s_rd_addr  = bidx;
        st_d       = fvslm_pkg::ST_INTERP;
      end
      fvslm_pkg::ST_INTERP: begin
        s_d   = 17'(a_q) + 17'(iprod >>> 16);
        nph_d = (nsum >= span_n) ? nsum - span_n : nsum;
        st_d  = fvslm_pkg::ST_VOLUME;
      end
      fvslm_pkg::ST_VOLUME: begin
        s_d   = 17'(vprod >>> 16);
        nph_d = (nph_q >= span_n) ? nph_q - span_n : nph_q;
        st_d  = fvslm_pkg::ST_PAN;
      end
      fvslm_pkg::ST_PAN: begin
        g_d  = $signed(17'h08000) - $signed({1'b0, pprod[30:15]});
        st_d = fvslm_pkg::ST_MIX;
      end
      fvslm_pkg::ST_MIX: begin
        accl_d = accl_q + AccW'((bal_q > 0) ? contrib : s_q);
        accr_d = accr_q + AccW'((bal_q < 0) ? contrib : s_q);
        vctl.wr_en = 1'b1;
        vwr    = {PhW'(nph_q), step_q, gain_q, gtgt_q, bal_q, btgt_q};
        vidx_d = vidx_q + ViW'(1);
        st_d   = last_voice ? fvslm_pkg::ST_DONE : fvslm_pkg::ST_TICK_RD;
      end
      fvslm_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {right_c, left_c};
          st_d        = fvslm_pkg::ST_IDLE;
        end
      end
      default: st_d = fvslm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= fvslm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      len_cfg_q   <= '0;
      muted_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid && cfg_ready) begin
        unique case (fvslm_pkg::reg_e'(cfg_index))
          fvslm_pkg::REG_SAMPLE_LENGTH: len_cfg_q <= cfg_data;
          fvslm_pkg::REG_ENGINE_MUTED:  muted_q   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vidx_q     <= vidx_d;
    rem_q      <= rem_d;
    kcnt_q     <= kcnt_d;
    step_q     <= step_d;
    gain_q     <= gain_d;
    gtgt_q     <= gtgt_d;
    bal_q      <= bal_d;
    btgt_q     <= btgt_d;
    a_q        <= a_d;
    s_q        <= s_d;
    g_q        <= g_d;
    nph_q      <= nph_d;
    accl_q     <= accl_d;
    accr_q     <= accr_d;
    out_data_q <= out_data_d;
    if (accept) begin
      rev_q <= s_axis_tdata[8:2];
      vol_q <= s_axis_tdata[24:9];
      pan_q <= s_axis_tdata[40:25];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  fvslm_sample_mem #(
    .DEPTH(SAMPLE_DEPTH),
    .AW   (IdxW)
  ) u_sample_mem (
    .clk_i    (clk_i),
    .ctl_i    (sctl),
    .wr_addr_i(ld_addr),
    .wr_data_i($signed(s_axis_tdata[68:53])),
    .rd_addr_i(s_rd_addr),
    .rd_data_o(s_rd)
  );

  fvslm_voice_mem #(
    .DEPTH(VOICE_COUNT),
    .AW   (ViW),
    .WIDTH(VW)
  ) u_voice_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (vctl),
    .rd_addr_i(vaddr),
    .rd_data_o(vrd),
    .wr_addr_i(vaddr),
    .wr_data_i(vwr)
  );

endmodule

[hdl/fvslm_checker.sv]
module fvslm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output transaction dropped while stalled.");

  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000)
    else $error("Output sample outside the clamp range.");

  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == fvslm_pkg::OP_TICK |=> !s_axis_tready)
    else $error("Input taken while a tick is in progress.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("Configuration port not ready.");

endmodule

bind four_voice_sample_loop_mixer_top fvslm_checker u_fvslm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_ready    (cfg_ready)
);

[bench/four_voice_sample_loop_mixer_checker.sv]
module four_voice_sample_loop_mixer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output int          errors_o,
  output int          pending_o
);

  localparam int Voices = 4;
  localparam int Depth  = 4096;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } frame_t;

  logic signed [15:0] pcm_store [Depth];
  longint             phase [Voices];
  longint             step [Voices];
  longint             gain [Voices];
  longint             gain_goal [Voices];
  longint             pan [Voices];
  longint             pan_goal [Voices];
  int unsigned        loop_len;
  bit                 muted;
  frame_t             frames_due [$];

  function automatic longint clamp_pcm(longint x);
    if (x > 32767) return 32767;
    if (x < -32767) return -32767;
    return x;
  endfunction

  function automatic frame_t mix_frame();
    longint len, span, lsum, rsum, a, b, s, p, g, j, f;
    frame_t fr;
    len  = (loop_len > Depth) ? Depth : loop_len;
    lsum = 0;
    rsum = 0;
    if (len >= 2) begin
      span = len << 16;
      for (int v = 0; v < Voices; v++) begin
        gain[v] += ((gain_goal[v] - gain[v]) * 131) >>> 16;
        pan[v]  += ((pan_goal[v] - pan[v]) * 131) >>> 16;
        if (gain[v] < 33) continue;
        j = phase[v] >> 16;
        f = phase[v] & 64'hFFFF;
        a = pcm_store[j % len];
        b = pcm_store[(j + 1) % len];
        s = a + (((b - a) * f) >>> 16);
        s = (s * gain[v]) >>> 16;
        p = pan[v];
        g = 32768 - ((((p < 0) ? -p : p) * 26214) >> 15);
        lsum += (p > 0) ? ((s * g) >>> 15) : s;
        rsum += (p < 0) ? ((s * g) >>> 15) : s;
        phase[v] = (phase[v] + step[v]) % span;
      end
    end
    fr.left  = 16'(clamp_pcm(lsum));
    fr.right = 16'(clamp_pcm(rsum));
    return fr;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fvslm_pkg::op_e op;
    int      vi, rev;
    longint  vol, pitch;
    frame_t  got, want;
    if (!rst_ni) begin
      for (int v = 0; v < Voices; v++) begin
        phase[v] = 0; step[v] = 0; gain[v] = 0;
        gain_goal[v] = 0; pan[v] = 0; pan_goal[v] = 0;
      end
      loop_len  = 0;
      muted     = 0;
      errors_o  = 0;
      frames_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (fvslm_pkg::reg_e'(cfg_index) == fvslm_pkg::REG_SAMPLE_LENGTH) loop_len = cfg_data;
        else muted = cfg_data[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op = fvslm_pkg::op_e'(s_axis_tuser);
        case (op)
          fvslm_pkg::OP_LOAD: begin
            pcm_store[s_axis_tdata[52:41]] = s_axis_tdata[68:53];
          end
          fvslm_pkg::OP_SET: begin
            vi  = s_axis_tdata[1:0];
            rev = s_axis_tdata[8:2];
            vol = s_axis_tdata[24:9];
            if (rev == 0 || vol == 0 || muted) begin
              gain_goal[vi] = 0;
            end else begin
              pitch        = (14'h3FFF & (32'h4700 + 34 * rev));
              step[vi]     = (pitch * 47554) >> 12;
              gain_goal[vi] = vol;
              pan_goal[vi]  = longint'($signed(s_axis_tdata[40:25]));
            end
          end
          fvslm_pkg::OP_SILENCE: begin
            for (int v = 0; v < Voices; v++) gain_goal[v] = 0;
          end
          default: begin
            frames_due.push_back(mix_frame());
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (frames_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("Unexpected output frame: left %0d right %0d", got.left, got.right);
        end else begin
          want = frames_due.pop_front();
          if (got.left !== want.left || got.right !== want.right) begin
            errors_o++;
            if (errors_o <= 10)
              $display("Frame mismatch: expected left %0d right %0d, got left %0d right %0d",
                       want.left, want.right, got.left, got.right);
          end
        end
      end
      pending_o = frames_due.size();
    end
  end

endmodule

[bench/four_voice_sample_loop_mixer_top_tb.sv]
module four_voice_sample_loop_mixer_top_tb;

  localparam int IdleLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          rdy_mode = 0;
  int          rdy_timer = 0;

  four_voice_sample_loop_mixer_top DUT (.*);

  four_voice_sample_loop_mixer_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .errors_o(errors), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rdy_timer == 0) begin
      rdy_mode  <= $urandom_range(0, 2);
      rdy_timer <= $urandom_range(20, 300);
    end else begin
      rdy_timer <= rdy_timer - 1;
    end
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL four_voice_sample_loop_mixer_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(fvslm_pkg::op_e op, logic [1:0] vi, logic [6:0] rev,
                           logic [15:0] vol, logic [15:0] pan, logic [11:0] addr,
                           logic [15:0] word);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, word, addr, pan, vol, rev, vi};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic write_reg(fvslm_pkg::reg_e idx, logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_item(fvslm_pkg::OP_TICK, 2'($urandom), 7'($urandom), 16'($urandom),
                  16'($urandom), 12'($urandom), 16'($urandom));
      else if (r < 75)
        send_item(fvslm_pkg::OP_SET, 2'($urandom), 7'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom),
                  16'($urandom), 12'($urandom), 16'($urandom));
      else if (r < 92)
        send_item(fvslm_pkg::OP_LOAD, 2'($urandom), 7'($urandom), 16'($urandom),
                  16'($urandom), 12'($urandom), 16'($urandom));
      else
        send_item(fvslm_pkg::OP_SILENCE, 2'($urandom), 7'($urandom), 16'($urandom),
                  16'($urandom), 12'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [12:0] len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first 512 words are written so that no tick ever reads an empty entry.
    for (int a = 0; a < 512; a++)
      send_item(fvslm_pkg::OP_LOAD, '0, '0, '0, '0, 12'(a), 16'($urandom));
    drain();
    write_reg(fvslm_pkg::REG_SAMPLE_LENGTH, 13'd16);
    write_reg(fvslm_pkg::REG_ENGINE_MUTED, 13'd0);

    send_item(fvslm_pkg::OP_LOAD, '0, '0, '0, '0, 12'd0, 16'h7FFF);
    send_item(fvslm_pkg::OP_LOAD, '0, '0, '0, '0, 12'd1, 16'h8000);
    send_item(fvslm_pkg::OP_LOAD, '0, '0, '0, '0, 12'd4095, 16'hFFFF);
    send_item(fvslm_pkg::OP_SET, 2'd0, 7'd127, 16'hFFFF, 16'h8000, '0, '0);
    send_item(fvslm_pkg::OP_SET, 2'd1, 7'd1, 16'h0001, 16'h7FFF, '0, '0);
    send_item(fvslm_pkg::OP_SET, 2'd2, 7'd0, 16'h8000, 16'h0000, '0, '0);
    send_item(fvslm_pkg::OP_SET, 2'd3, 7'd64, 16'h0000, 16'h4000, '0, '0);
    send_item(fvslm_pkg::OP_SET, 2'd3, 7'd64, 16'h4000, 16'h0000, '0, '0);
    send_item(fvslm_pkg::OP_SET, 2'd2, 7'd100, 16'hC000, 16'hC000, '0, '0);
    for (int i = 0; i < 8; i++)
      send_item(fvslm_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
    send_item(fvslm_pkg::OP_SILENCE, '0, '0, '0, '0, '0, '0);
    send_item(fvslm_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
    send_item(fvslm_pkg::OP_SET, 2'd1, 7'd50, 16'hFFFF, 16'h0000, '0, '0);
    send_item(fvslm_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
    drain();

    write_reg(fvslm_pkg::REG_ENGINE_MUTED, 13'd1);
    send_item(fvslm_pkg::OP_SET, 2'd0, 7'd90, 16'hFFFF, 16'h1234, '0, '0);
    send_item(fvslm_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
    drain();
    write_reg(fvslm_pkg::REG_ENGINE_MUTED, 13'd0);
    write_reg(fvslm_pkg::REG_SAMPLE_LENGTH, 13'd1);
    send_item(fvslm_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
    drain();
    write_reg(fvslm_pkg::REG_SAMPLE_LENGTH, 13'd0);
    send_item(fvslm_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       len = 13'd2;
        3:       len = 13'h1FFF;
        6:       len = 13'd4096;
        8:       len = 13'd1;
        default: len = 13'($urandom_range(2, 300));
      endcase
      write_reg(fvslm_pkg::REG_SAMPLE_LENGTH, len);
      write_reg(fvslm_pkg::REG_ENGINE_MUTED, 13'(ph == 4 || $urandom_range(0, 5) == 0));
      random_items((len > 300) ? 40 : 100);
      drain();
    end

    if (errors == 0) begin
      $display("PASS four_voice_sample_loop_mixer_top");
    end else begin
      $display("FAIL four_voice_sample_loop_mixer_top");
    end
    $finish;
  end

endmodule
